[rtl/core/cfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU package
// Shared types, opcodes and sizes for the constant fold ALU.
// ----------------------------------------------------------------------------
package cfa_pkg;

   localparam int DATA_W        = 64;
   localparam int HALF_W        = DATA_W / 2;
   localparam int CMD_W         = 5;
   localparam int ERR_W         = 2;
   localparam int QUEUE_DEPTH_D = 4;

   localparam logic [CMD_W-1:0] CMD_PLUS     = 5'd0;
   localparam logic [CMD_W-1:0] CMD_NEG      = 5'd1;
   localparam logic [CMD_W-1:0] CMD_NOT      = 5'd2;
   localparam logic [CMD_W-1:0] CMD_LNOT     = 5'd3;
   localparam logic [CMD_W-1:0] CMD_INCDEC   = 5'd4;
   localparam logic [CMD_W-1:0] CMD_ADD      = 5'd5;
   localparam logic [CMD_W-1:0] CMD_SUB      = 5'd6;
   localparam logic [CMD_W-1:0] CMD_MUL      = 5'd7;
   localparam logic [CMD_W-1:0] CMD_DIV      = 5'd8;
   localparam logic [CMD_W-1:0] CMD_MOD      = 5'd9;
   localparam logic [CMD_W-1:0] CMD_SHL      = 5'd10;
   localparam logic [CMD_W-1:0] CMD_SHR      = 5'd11;
   localparam logic [CMD_W-1:0] CMD_AND      = 5'd12;
   localparam logic [CMD_W-1:0] CMD_OR       = 5'd13;
   localparam logic [CMD_W-1:0] CMD_XOR      = 5'd14;
   localparam logic [CMD_W-1:0] CMD_LT       = 5'd15;
   localparam logic [CMD_W-1:0] CMD_LE       = 5'd16;
   localparam logic [CMD_W-1:0] CMD_GT       = 5'd17;
   localparam logic [CMD_W-1:0] CMD_GE       = 5'd18;
   localparam logic [CMD_W-1:0] CMD_EQ       = 5'd19;
   localparam logic [CMD_W-1:0] CMD_NE       = 5'd20;
   localparam logic [CMD_W-1:0] CMD_LAND     = 5'd21;
   localparam logic [CMD_W-1:0] CMD_LOR      = 5'd22;
   localparam logic [CMD_W-1:0] CMD_COMPOUND = 5'd23;

   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;
   localparam logic [ERR_W-1:0] ERR_NOT_MOD  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] a_value;
      logic              a_sgn;
      logic              a_const;
      logic              a_ok;
      logic [DATA_W-1:0] b_value;
      logic              b_sgn;
      logic              b_const;
      logic              b_ok;
   } req_type;

   typedef struct packed {
      logic              res_ok;
      logic              res_const;
      logic              res_signed;
      logic [DATA_W-1:0] res_value;
      logic [ERR_W-1:0]  err_code;
   } rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              sgn;
      logic              fixed;
      logic              fix_ok;
      logic              fix_cst;
      logic [ERR_W-1:0]  fix_err;
   } entry_type;

endpackage

[rtl/core/cfa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU front end
// Checks operand tags and marks words whose result needs no arithmetic.
// ----------------------------------------------------------------------------
module cfa_front
   import cfa_pkg::*;
(
   input  req_type   req,
   output entry_type entry
);

   logic unary;

   always_comb begin
      unary         = req.cmd inside {[CMD_PLUS:CMD_INCDEC]};
      entry.cmd     = req.cmd;
      entry.a       = req.a_value;
      entry.b       = req.b_value;
      entry.sgn     = unary ? req.a_sgn : (req.a_sgn | req.b_sgn);
      entry.fixed   = 1'b0;
      entry.fix_ok  = 1'b0;
      entry.fix_cst = 1'b0;
      entry.fix_err = ERR_NONE;
      if (unary) begin
         if (!req.a_ok) begin
            entry.fixed = 1'b1;
         end else if (!req.a_const) begin
            entry.fixed  = 1'b1;
            entry.fix_ok = 1'b1;
         end else if (req.cmd == CMD_INCDEC) begin
            entry.fixed   = 1'b1;
            entry.fix_err = ERR_NOT_MOD;
         end
      end else begin
         if (!req.a_ok || !req.b_ok) begin
            entry.fixed = 1'b1;
         end else if (!req.a_const || !req.b_const) begin
            entry.fixed  = 1'b1;
            entry.fix_ok = 1'b1;
         end else if (req.cmd == CMD_COMPOUND) begin
            entry.fixed   = 1'b1;
            entry.fix_err = ERR_NOT_MOD;
         end else if (req.cmd > CMD_COMPOUND) begin
            entry.fixed  = 1'b1;
            entry.fix_ok = 1'b1;
         end
      end
   end

endmodule

[rtl/core/cfa_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU queue
// Small FIFO that decouples the front end from the execution pipeline.
// ----------------------------------------------------------------------------
module cfa_queue
   import cfa_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_D
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/cfa_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU back end
// Execution pipeline: simple ops and multiplier partial products first,
// then the product sum, a one-bit-per-stage divider and the output register.
// ----------------------------------------------------------------------------
module cfa_back
   import cfa_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  entry_type in_entry,
   output logic      in_take,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   localparam int LAST = DATA_W;

   typedef struct packed {
      logic              is_mul;
      logic              is_div;
      logic              is_mod;
      logic              neg_q;
      logic              neg_r;
      logic              ok;
      logic              cst;
      logic              sgn;
      logic [ERR_W-1:0]  err;
      logic [DATA_W-1:0] value;
   } pipe_type;

   pipe_type          pipe_ff [LAST+1];
   pipe_type          pipe_in [LAST+1];
   logic [LAST:0]     valid_ff;
   logic [DATA_W-1:0] rem_ff [1:LAST];
   logic [DATA_W-1:0] rem_in [1:LAST];
   logic [DATA_W-1:0] dvs_ff [0:LAST-1];
   logic [DATA_W-1:0] dvs_in [0:LAST-1];
   logic [DATA_W-1:0] pp_ff [4];
   logic [DATA_W-1:0] pp_in [4];
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              adv;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign in_take   = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [DATA_W-1:0] a, b, sum, mag_a, mag_b;
      logic              less_u, less_s, lt, gt;
      a         = in_entry.a;
      b         = in_entry.b;
      sum       = a + b;
      mag_a     = a[DATA_W-1] ? (~a + 1'b1) : a;
      mag_b     = b[DATA_W-1] ? (~b + 1'b1) : b;
      less_u    = a < b;
      less_s    = (a ^ {1'b1, {(DATA_W-1){1'b0}}}) < (b ^ {1'b1, {(DATA_W-1){1'b0}}});
      lt        = in_entry.sgn ? less_s : less_u;
      gt        = !lt && (a != b);
      pipe_in[0]        = '0;
      pipe_in[0].ok     = 1'b1;
      pipe_in[0].cst    = 1'b1;
      pipe_in[0].err    = ERR_NONE;
      dvs_in[0]         = b;
      pp_in[0] = DATA_W'(a[HALF_W-1:0] * b[HALF_W-1:0]);
      pp_in[1] = DATA_W'(a[HALF_W-1:0] * b[DATA_W-1:HALF_W]);
      pp_in[2] = DATA_W'(a[DATA_W-1:HALF_W] * b[HALF_W-1:0]);
      pp_in[3] = DATA_W'(a[DATA_W-1:HALF_W] * b[DATA_W-1:HALF_W]);
      if (in_entry.fixed) begin
         pipe_in[0].ok  = in_entry.fix_ok;
         pipe_in[0].cst = in_entry.fix_cst;
         pipe_in[0].err = in_entry.fix_err;
      end else begin
         case (in_entry.cmd)
            CMD_PLUS: begin
               pipe_in[0].sgn   = in_entry.sgn;
               pipe_in[0].value = a;
            end
            CMD_NEG: begin
               pipe_in[0].sgn   = 1'b1;
               pipe_in[0].value = ~a + 1'b1;
            end
            CMD_NOT:  pipe_in[0].value = ~a;
            CMD_LNOT: pipe_in[0].value = DATA_W'(a == '0);
            CMD_ADD: begin
               if (!in_entry.sgn && (sum < a)) begin
                  pipe_in[0].ok  = 1'b0;
                  pipe_in[0].cst = 1'b0;
                  pipe_in[0].err = ERR_OVERFLOW;
               end else begin
                  pipe_in[0].sgn   = in_entry.sgn;
                  pipe_in[0].value = sum;
               end
            end
            CMD_SUB: begin
               if (!in_entry.sgn && less_u) begin
                  pipe_in[0].ok  = 1'b0;
                  pipe_in[0].cst = 1'b0;
                  pipe_in[0].err = ERR_OVERFLOW;
               end else begin
                  pipe_in[0].sgn   = in_entry.sgn;
                  pipe_in[0].value = a - b;
               end
            end
            CMD_MUL: begin
               pipe_in[0].is_mul = 1'b1;
               pipe_in[0].sgn    = in_entry.sgn;
            end
            CMD_DIV, CMD_MOD: begin
               if (b == '0) begin
                  pipe_in[0].ok  = 1'b0;
                  pipe_in[0].cst = 1'b0;
                  pipe_in[0].err = ERR_DIV_ZERO;
               end else begin
                  pipe_in[0].is_div = 1'b1;
                  pipe_in[0].is_mod = (in_entry.cmd == CMD_MOD);
                  pipe_in[0].sgn    = in_entry.sgn;
                  pipe_in[0].neg_q  = in_entry.sgn && (a[DATA_W-1] ^ b[DATA_W-1]);
                  pipe_in[0].neg_r  = in_entry.sgn && a[DATA_W-1];
                  pipe_in[0].value  = in_entry.sgn ? mag_a : a;
                  dvs_in[0]         = in_entry.sgn ? mag_b : b;
               end
            end
            CMD_SHL: pipe_in[0].value = (b[7:6] != 2'b00) ? '0 : (a << b[5:0]);
            CMD_SHR: pipe_in[0].value = (b[7:6] != 2'b00) ? '0 : (a >> b[5:0]);
            CMD_AND: pipe_in[0].value = a & b;
            CMD_OR:  pipe_in[0].value = a | b;
            CMD_XOR: pipe_in[0].value = a ^ b;
            CMD_LT:  pipe_in[0].value = DATA_W'(lt);
            CMD_LE:  pipe_in[0].value = DATA_W'(!gt);
            CMD_GT:  pipe_in[0].value = DATA_W'(gt);
            CMD_GE:  pipe_in[0].value = DATA_W'(!lt);
            CMD_EQ:  pipe_in[0].value = DATA_W'(a == b);
            CMD_NE:  pipe_in[0].value = DATA_W'(a != b);
            CMD_LAND: pipe_in[0].value = DATA_W'((a != '0) && (b != '0));
            CMD_LOR:  pipe_in[0].value = DATA_W'((a != '0) || (b != '0));
            default: begin
               pipe_in[0].ok  = 1'b1;
               pipe_in[0].cst = 1'b0;
            end
         endcase
      end
   end

   for (genvar i = 1; i <= LAST; i++) begin : g_stage
      always_comb begin
         logic [DATA_W:0]   t, diff;
         logic              ge;
         logic [DATA_W-1:0] r_prev;
         logic [2*DATA_W-1:0] prod;
         r_prev = (i == 1) ? '0 : rem_ff[(i == 1) ? 1 : i - 1];
         t      = {r_prev, pipe_ff[i-1].value[DATA_W-1]};
         diff   = t - {1'b0, dvs_ff[i-1]};
         ge     = (t >= {1'b0, dvs_ff[i-1]});
         prod   = '0;
         pipe_in[i] = pipe_ff[i-1];
         rem_in[i]  = r_prev;
         if (pipe_ff[i-1].is_div) begin
            rem_in[i]        = ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];
            pipe_in[i].value = {pipe_ff[i-1].value[DATA_W-2:0], ge};
         end else if ((i == 1) && pipe_ff[i-1].is_mul) begin
            prod = {{DATA_W{1'b0}}, pp_ff[0]}
                 + ({{DATA_W{1'b0}}, pp_ff[1]} << HALF_W)
                 + ({{DATA_W{1'b0}}, pp_ff[2]} << HALF_W)
                 + {pp_ff[3], {DATA_W{1'b0}}};
            if (!pipe_ff[i-1].sgn && (prod[2*DATA_W-1:DATA_W] != '0)) begin
               pipe_in[i].ok  = 1'b0;
               pipe_in[i].cst = 1'b0;
               pipe_in[i].err = ERR_OVERFLOW;
            end else begin
               pipe_in[i].value = prod[DATA_W-1:0];
            end
         end
      end
   end

   for (genvar i = 1; i < LAST; i++) begin : g_dvs
      assign dvs_in[i] = dvs_ff[i-1];
   end

   always_comb begin
      pipe_type          p;
      logic [DATA_W-1:0] q, r;
      p = pipe_ff[LAST];
      q = p.neg_q ? (~p.value + 1'b1) : p.value;
      r = p.neg_r ? (~rem_ff[LAST] + 1'b1) : rem_ff[LAST];
      rsp_in.res_ok     = p.ok;
      rsp_in.res_const  = p.cst;
      rsp_in.res_signed = (p.ok && p.cst) ? p.sgn : 1'b0;
      rsp_in.err_code   = p.err;
      rsp_in.res_value  = !p.is_div ? p.value : (p.is_mod ? r : q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff     <= {valid_ff[LAST-1:0], in_valid};
         rsp_valid_ff <= valid_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= LAST; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         for (int k = 1; k <= LAST; k++) begin
            rem_ff[k] <= rem_in[k];
         end
         for (int k = 0; k < LAST; k++) begin
            dvs_ff[k] <= dvs_in[k];
         end
         for (int k = 0; k < 4; k++) begin
            pp_ff[k] <= pp_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/core/constant_fold_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU
// 64-bit ALU on tagged constant operands with a queued execution pipeline.
// ----------------------------------------------------------------------------
// An accepted word passes through the queue, pipeline stage 0, the 64 divider stages and the output register.
// Throughput: one word per cycle unless a stalled result holds the pipeline; the 64-stage divider sets the depth.
// A stalled result freezes the pipeline and the queue absorbs new words.
// Reset: synchronous, clears the queue pointers and all valid flags.
module constant_fold_alu_unit
   import cfa_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   entry_type front_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      back_take;

   assign req_stall = q_full;

   cfa_front u_front (
      .req   (req_data),
      .entry (front_entry)
   );

   cfa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_entry),
      .full      (q_full),
      .pop       (back_take),
      .not_empty (q_not_empty),
      .head      (head_entry)
   );

   cfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_entry  (head_entry),
      .in_take   (back_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/sv/tb_constant_fold_alu_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant fold ALU testbench
// Drives tagged operand words through the ALU with random gaps on both sides
// and checks every result word against an in-order prediction queue.
// ----------------------------------------------------------------------------
module tb_constant_fold_alu_unit;
   import cfa_pkg::*;

   localparam int LATENCY   = 66;
   localparam int MAX_CYCLE = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type folded_results[$];
   int      error_count;
   int      checked_count;
   int      sent_count;
   int      cycle_count;
   int      send_gap;
   int      recv_gap;
   bit      stim_done;
   bit      hold_off;

   constant_fold_alu_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type fold_word(req_type w);
      rsp_type r;
      logic [DATA_W-1:0] a, b, q, ma, mb;
      logic sgn;
      logic [7:0] sh;
      r = '0;
      a = w.a_value;
      b = w.b_value;
      if (w.cmd <= CMD_INCDEC) begin
         if (!w.a_ok) return r;
         r.res_ok = 1'b1;
         if (!w.a_const) return r;
         r.res_const = 1'b1;
         case (w.cmd)
            CMD_PLUS: begin
               r.res_signed = w.a_sgn;
               r.res_value = a;
            end
            CMD_NEG: begin
               r.res_signed = 1'b1;
               r.res_value = -a;
            end
            CMD_NOT: r.res_value = ~a;
            CMD_LNOT: r.res_value = DATA_W'(a == 0);
            default: begin
               r = '0;
               r.err_code = ERR_NOT_MOD;
            end
         endcase
         return r;
      end
      if (!w.a_ok || !w.b_ok) return r;
      r.res_ok = 1'b1;
      if (!w.a_const || !w.b_const) return r;
      r.res_const = 1'b1;
      sgn = w.a_sgn | w.b_sgn;
      case (w.cmd)
         CMD_ADD, CMD_SUB, CMD_MUL: begin
            if (w.cmd == CMD_ADD) q = a + b;
            else if (w.cmd == CMD_SUB) q = a - b;
            else q = a * b;
            if (sgn) begin
               r.res_signed = 1'b1;
               r.res_value = q;
            end else if ((w.cmd == CMD_ADD && q < a) || (w.cmd == CMD_SUB && a < b)
                         || (w.cmd == CMD_MUL && a != 0 && q / a != b)) begin
               r = '0;
               r.err_code = ERR_OVERFLOW;
            end else begin
               r.res_value = q;
            end
         end
         CMD_DIV, CMD_MOD: begin
            if (b == 0) begin
               r = '0;
               r.err_code = ERR_DIV_ZERO;
            end else if (sgn) begin
               r.res_signed = 1'b1;
               ma = a[DATA_W-1] ? -a : a;
               mb = b[DATA_W-1] ? -b : b;
               if (w.cmd == CMD_DIV) begin
                  q = ma / mb;
                  r.res_value = (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
               end else begin
                  q = ma % mb;
                  r.res_value = a[DATA_W-1] ? -q : q;
               end
            end else begin
               r.res_value = (w.cmd == CMD_DIV) ? a / b : a % b;
            end
         end
         CMD_SHL, CMD_SHR: begin
            sh = b[7:0];
            if (sh < 64) r.res_value = (w.cmd == CMD_SHL) ? a << sh : a >> sh;
         end
         CMD_AND: r.res_value = a & b;
         CMD_OR: r.res_value = a | b;
         CMD_XOR: r.res_value = a ^ b;
         CMD_LT: r.res_value = DATA_W'(sgn ? ($signed(a) < $signed(b)) : (a < b));
         CMD_LE: r.res_value = DATA_W'(sgn ? ($signed(a) <= $signed(b)) : (a <= b));
         CMD_GT: r.res_value = DATA_W'(sgn ? ($signed(a) > $signed(b)) : (a > b));
         CMD_GE: r.res_value = DATA_W'(sgn ? ($signed(a) >= $signed(b)) : (a >= b));
         CMD_EQ: r.res_value = DATA_W'(a == b);
         CMD_NE: r.res_value = DATA_W'(a != b);
         CMD_LAND: r.res_value = DATA_W'(a != 0 && b != 0);
         CMD_LOR: r.res_value = DATA_W'(a != 0 || b != 0);
         CMD_COMPOUND: begin
            r = '0;
            r.err_code = ERR_NOT_MOD;
         end
         default: r.res_const = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_operand();
      logic [DATA_W-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = {1'b1, {(DATA_W-1){1'b0}}};
         3: v = {1'b0, {(DATA_W-1){1'b1}}};
         4: v = DATA_W'($urandom_range(0, 300));
         5: v = -DATA_W'($urandom_range(1, 300));
         6: v = {32'h0, $urandom};
         default: ;
      endcase
      return v;
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 2) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b, input logic as, input logic bs);
      req_type w;
      w = '0;
      w.cmd = cmd;
      w.a_value = a;
      w.b_value = b;
      w.a_sgn = as;
      w.b_sgn = bs;
      w.a_const = 1'b1;
      w.b_const = 1'b1;
      w.a_ok = 1'b1;
      w.b_ok = 1'b1;
      pending_words.push_back(w);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            folded_results.push_back(fold_word(req_data));
            sent_count <= sent_count + 1;
         end
         if (req_valid && req_stall) begin
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_words.size() > 0 && !hold_off) begin
            req_valid <= 1'b1;
            req_data <= pending_words.pop_front();
            send_gap <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (folded_results.size() == 0) begin
               $display("%0t: unexpected result word %h", $realtime, rsp_data);
               error_count++;
            end else begin
               rsp_type e;
               e = folded_results.pop_front();
               checked_count++;
               if (e.res_ok !== rsp_data.res_ok || e.res_const !== rsp_data.res_const
                   || e.res_signed !== rsp_data.res_signed
                   || e.res_value !== rsp_data.res_value
                   || e.err_code !== rsp_data.err_code) begin
                  $display("%0t: mismatch expected ok=%b const=%b signed=%b value=%h err=%0d",
                           $realtime, e.res_ok, e.res_const, e.res_signed, e.res_value,
                           e.err_code);
                  $display("%0t:          actual ok=%b const=%b signed=%b value=%h err=%0d",
                           $realtime, rsp_data.res_ok, rsp_data.res_const,
                           rsp_data.res_signed, rsp_data.res_value, rsp_data.err_code);
                  error_count++;
               end
            end
         end
         if (recv_gap > 0) begin
            rsp_stall <= 1'b1;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_stall <= 1'b0;
            recv_gap <= stim_done ? 0 : pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= MAX_CYCLE) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("tb_constant_fold_alu_unit: done, errors");
         $finish;
      end
   end

   initial begin
      req_type w;
      logic [DATA_W-1:0] min_s;
      int total;
      min_s = {1'b1, {(DATA_W-1){1'b0}}};
      error_count = 0;
      checked_count = 0;
      sent_count = 0;
      cycle_count = 0;
      stim_done = 1'b0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int c = 0; c <= CMD_COMPOUND; c++) begin
         queue_word(CMD_W'(c), 64'd7, 64'd3, 1'b0, 1'b0);
      end
      queue_word(CMD_ADD, '1, 64'd1, 1'b0, 1'b0);
      queue_word(CMD_SUB, 64'd1, 64'd2, 1'b0, 1'b0);
      queue_word(CMD_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 1'b0, 1'b0);
      queue_word(CMD_DIV, 64'd5, 64'd0, 1'b1, 1'b0);
      queue_word(CMD_MOD, 64'd5, 64'd0, 1'b0, 1'b0);
      queue_word(CMD_DIV, min_s, '1, 1'b1, 1'b0);
      queue_word(CMD_MOD, min_s, '1, 1'b0, 1'b1);
      queue_word(CMD_SHL, '1, 64'h140, 1'b0, 1'b0);
      queue_word(CMD_SHR, '1, 64'd64, 1'b0, 1'b0);
      queue_word(CMD_NEG, min_s, '0, 1'b0, 1'b0);
      w = '0;
      w.cmd = CMD_ADD;
      w.b_ok = 1'b1;
      w.b_const = 1'b1;
      pending_words.push_back(w);
      w.a_ok = 1'b1;
      pending_words.push_back(w);
      w.cmd = CMD_INCDEC;
      pending_words.push_back(w);
      w.cmd = 5'd27;
      w.a_const = 1'b1;
      pending_words.push_back(w);

      total = 700;
      for (int i = 0; i < total; i++) begin
         w.cmd = ($urandom_range(0, 15) == 0) ? CMD_W'($urandom_range(24, 31))
                                              : CMD_W'($urandom_range(0, 23));
         w.a_value = pick_operand();
         w.b_value = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 255))
                                                 : pick_operand();
         w.a_sgn = 1'($urandom_range(0, 1));
         w.b_sgn = 1'($urandom_range(0, 1));
         w.a_ok = ($urandom_range(0, 11) != 0);
         w.b_ok = ($urandom_range(0, 11) != 0);
         w.a_const = ($urandom_range(0, 7) != 0);
         w.b_const = ($urandom_range(0, 7) != 0);
         pending_words.push_back(w);
         if (i == total / 2) begin
            wait (pending_words.size() == 0);
            @(posedge clock);
            hold_off <= 1'b1;
            wait (folded_results.size() == 0 && !req_valid);
            @(posedge clock);
            hold_off <= 1'b0;
         end
      end

      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req_valid) @(posedge clock);
      stim_done = 1'b1;
      while (folded_results.size() > 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d words through all opcodes, tag mixes and edge operands.", sent_count);
      $display("Checked %0d result words under random stalls on both channels.", checked_count);
      if (folded_results.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("tb_constant_fold_alu_unit: done, clean");
      end else begin
         $display("tb_constant_fold_alu_unit: done, errors");
      end
      $finish;
   end

endmodule
